### hw/rtl/nearest_centroid_classifier_macros.svh
// Assertion macros shared by the nearest centroid classifier RTL.
`ifndef NEAREST_CENTROID_CLASSIFIER_MACROS_SVH
`define NEAREST_CENTROID_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ncc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NCC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ncc assertion failed");

`endif

### hw/rtl/ncc_pkg.sv
// Types, constants and codes shared by the nearest centroid classifier.
`timescale 1ns / 1ps
package ncc_pkg;

    localparam int DIM_DEFAULT          = 16;
    localparam int MAX_CLUSTERS_DEFAULT = 16;

    localparam int VAL_W  = 16;
    localparam int DIFF_W = 17;
    localparam int SQ_W   = 32;
    localparam int ACC_W  = 37;
    localparam int DIST_W = 36;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 5;
    localparam int PADDR_W = 3;

    localparam logic [ACC_W-1:0]  ACC_MAX = {ACC_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [CNT_W-1:0]  NUM_CLUSTERS_RESET = 5'd11;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_NUM_CLUSTERS = 1'b0;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_POINT = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic [3:0]              cluster;
        logic [3:0]              element;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } in_item_t;

    typedef struct packed {
        logic [3:0]        nearest_cluster;
        logic [DIST_W-1:0] sq_dist;
    } out_item_t;

    // Item as it travels from cell to cell.
    typedef struct packed {
        logic                    valid;
        cmd_t                    cmd;
        logic [3:0]              cluster;
        logic [3:0]              element;
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic [CNT_W-1:0]        n_active;
    } token_t;

    // Per-stage control inside a cell.
    typedef struct packed {
        logic add;
        logic fin;
        logic active;
    } ctl_t;

    // Running minimum handed along the chain.
    typedef struct packed {
        logic              res;
        logic [IDX_W-1:0]  idx;
        logic [ACC_W-1:0]  score;
    } best_t;

    localparam best_t BEST_INIT = '{res: 1'b0, idx: '0, score: ACC_MAX};

endpackage

### hw/rtl/nearest_centroid_classifier.sv
// Top level of the nearest centroid classifier: register port, cell chain, output buffer.
//
// Usage: items arrive on the s_ channel (s_valid, s_ready, s_item). A load item
// (cmd 0) writes one element of one centroid; a point item (cmd 1) brings one
// element of a point vector. The point item marked last produces exactly one
// transfer on the m_ channel (m_valid, m_ready, m_item) carrying the lowest
// numbered active cluster with the smallest squared distance, and that distance.
// Throughput is one item per cycle, loads and points alike, unless the chain holds: every
// cluster has its own cell with a private centroid memory port, and items march down the
// chain of cells one cell per cycle while it advances. A result is registered in each
// cell's best register in turn and then in the output register before it shows on m_valid.
// The num_clusters register sits at byte address 0 of the APB-style port and
// must only be written while the block is idle. Reset clears the accumulators
// and sets num_clusters to 11; centroid memories are not cleared and must be
// loaded before use. When the receiver stalls, the result waits in the output
// register and one more result can land in a skid stage; only then does
// s_ready drop and the whole chain hold.
`timescale 1ns / 1ps
module nearest_centroid_classifier import ncc_pkg::*; #(
    parameter int DIM          = DIM_DEFAULT,
    parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Input items.
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    // Results.
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CNT_W-1:0] num_clusters_reg, num_clusters_next;
    logic [CNT_W-1:0] n_active;
    logic             cfg_wr, reg_hit;
    logic             adv;

    token_t    tok  [MAX_CLUSTERS+1];
    best_t     best [MAX_CLUSTERS+1];
    out_item_t res_item;
    best_t     fin;

    // The register write completes in the access phase; pready is tied high.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_hit = (paddr[PADDR_W-1] == REG_NUM_CLUSTERS);
    assign prdata  = reg_hit ? 32'(num_clusters_reg) : '0;

    always_comb begin
        num_clusters_next = num_clusters_reg;
        if (cfg_wr && reg_hit) begin
            num_clusters_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_clusters_reg <= NUM_CLUSTERS_RESET;
        end else begin
            num_clusters_reg <= num_clusters_next;
        end
    end

    // A count of zero behaves as one, and a count past the cell count is clamped.
    always_comb begin
        if (num_clusters_reg == '0) begin
            n_active = CNT_W'(1);
        end else if (int'(num_clusters_reg) > MAX_CLUSTERS) begin
            n_active = CNT_W'(MAX_CLUSTERS);
        end else begin
            n_active = num_clusters_reg;
        end
    end

    // The chain moves as one; it holds only while the skid stage is occupied.
    assign s_ready = adv;

    assign tok[0]  = '{valid: s_valid, cmd: s_item.cmd, cluster: s_item.cluster,
                       element: s_item.element, value: s_item.value,
                       last: s_item.last, n_active: n_active};
    assign best[0] = BEST_INIT;

    for (genvar k = 0; k < MAX_CLUSTERS; k++) begin : g_cell
        ncc_cell #(
            .DIM          (DIM),
            .CELL_ID      (k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .best_in  (best[k]),
            .best_out (best[k+1])
        );
    end

    // The distance saturates to the width of the result field.
    always_comb begin
        fin                      = best[MAX_CLUSTERS];
        res_item.nearest_cluster = fin.idx[3:0];
        res_item.sq_dist         = fin.score[ACC_W-1] ? DIST_MAX : fin.score[DIST_W-1:0];
    end

    ncc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fin.res),
        .in_data  (res_item),
        .in_ready (adv),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

### hw/rtl/ncc_cell.sv
// One cluster cell: centroid memory, squared-difference pipeline, accumulator, compare.
`timescale 1ns / 1ps
module ncc_cell import ncc_pkg::*; #(
    parameter int DIM          = DIM_DEFAULT,
    parameter int CELL_ID      = 0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  token_t tok_in,
    output token_t tok_out,
    input  best_t  best_in,
    output best_t  best_out
);

    localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;

    logic [VAL_W-1:0] mem [DIM];

    token_t                   tok_reg;
    logic [VAL_W-1:0]         rd_reg;
    ctl_t                     s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    ctl_t                     s1_ctl_next;
    logic signed [VAL_W-1:0]  p1_reg;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [SQ_W-1:0]          prod;
    logic [SQ_W-1:0]          sq_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next, acc_upd;
    logic [ACC_W:0]           sum;
    best_t                    best_reg, best_next;

    logic          in_range, is_point, is_active, wr_en;
    logic [AW-1:0] rd_addr;

    always_comb begin
        in_range  = int'(tok_reg.element) < DIM;
        is_point  = tok_reg.valid && (tok_reg.cmd == CMD_POINT);
        is_active = CELL_ID < int'(tok_reg.n_active);
        wr_en     = tok_reg.valid && (tok_reg.cmd == CMD_LOAD) && in_range &&
                    (int'(tok_reg.cluster) == CELL_ID);
        rd_addr   = in_range ? AW'(tok_reg.element) : '0;

        s1_ctl_next.add    = is_point && in_range && is_active;
        s1_ctl_next.fin    = is_point && tok_reg.last;
        s1_ctl_next.active = is_active;
    end

    // Centroid memory for this cluster, one word per vector element.
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (wr_en) begin
                mem[rd_addr] <= tok_reg.value;
            end
            rd_reg <= mem[rd_addr];
        end
    end

    // The square of a 17-bit difference always fits in 32 bits.
    always_comb begin
        diff_next = {p1_reg[VAL_W-1], p1_reg} - {rd_reg[VAL_W-1], rd_reg};
        prod      = diff_reg * diff_reg;
    end

    // Accumulate, then on the final element compete against the upstream minimum.
    always_comb begin
        sum     = {1'b0, acc_reg} + {{(ACC_W + 1 - SQ_W){1'b0}}, sq_reg};
        acc_upd = s3_ctl_reg.add ? (sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0]) : acc_reg;

        acc_next      = acc_upd;
        best_next     = best_in;
        best_next.res = s3_ctl_reg.fin;
        if (s3_ctl_reg.fin) begin
            acc_next = '0;
            if (s3_ctl_reg.active && (acc_upd < best_in.score)) begin
                best_next.idx   = IDX_W'(CELL_ID);
                best_next.score = acc_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
            s1_ctl_reg    <= '0;
            s2_ctl_reg    <= '0;
            s3_ctl_reg    <= '0;
            acc_reg       <= '0;
            best_reg.res  <= 1'b0;
        end else if (adv) begin
            tok_reg    <= tok_in;
            s1_ctl_reg <= s1_ctl_next;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            acc_reg    <= acc_next;
            best_reg   <= best_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_reg   <= tok_reg.value;
            diff_reg <= diff_next;
            sq_reg   <= prod;
        end
    end

    assign tok_out  = tok_reg;
    assign best_out = best_reg;

endmodule

### hw/rtl/ncc_out_buf.sv
// Output register with a skid stage between the cell chain and the result channel.
`timescale 1ns / 1ps
`include "nearest_centroid_classifier_macros.svh"
module ncc_out_buf import ncc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  out_item_t in_data,
    output logic      in_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_data_reg, out_data_next;
    out_item_t skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || m_ready) begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_data_reg;

    `NCC_ASSERT_IMP(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `NCC_ASSERT_NXT(a_stall_fills_skid, aclk, aresetn, out_valid_reg && !m_ready && in_valid && !skid_valid_reg, skid_valid_reg && out_valid_reg)
    `NCC_ASSERT_NXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_ready, !skid_valid_reg && out_valid_reg)

endmodule
